/* design/svg_path_syntax_checker_top_assert.svh */
// Assertion macros shared by the path syntax checker modules.
`ifndef SVG_PATH_SYNTAX_CHECKER_TOP_ASSERT_SVH
`define SVG_PATH_SYNTAX_CHECKER_TOP_ASSERT_SVH

// Same-cycle implication, checked on aclk, off while in reset.
`define SVGP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk, off while in reset.
`define SVGP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/svgp_pkg.sv */
// Types, codes and grammar step functions for the path syntax checker.
package svgp_pkg;

    // scan phases
    localparam logic [3:0] PH_TOP       = 4'd0;
    localparam logic [3:0] PH_SEP       = 4'd1;
    localparam logic [3:0] PH_SEP_COMMA = 4'd2;
    localparam logic [3:0] PH_SIGN      = 4'd3;
    localparam logic [3:0] PH_INT       = 4'd4;
    localparam logic [3:0] PH_DOT       = 4'd5;
    localparam logic [3:0] PH_FRAC      = 4'd6;
    localparam logic [3:0] PH_EXP       = 4'd7;
    localparam logic [3:0] PH_EXP_SIGN  = 4'd8;
    localparam logic [3:0] PH_EXP_DIG   = 4'd9;

    // verdict codes
    localparam logic [1:0] VERDICT_OPEN    = 2'd0;
    localparam logic [1:0] VERDICT_VALID   = 2'd1;
    localparam logic [1:0] VERDICT_INVALID = 2'd2;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UC    = 8'h43;
    localparam logic [7:0] CH_UE    = 8'h45;
    localparam logic [7:0] CH_UH    = 8'h48;
    localparam logic [7:0] CH_UL    = 8'h4C;
    localparam logic [7:0] CH_UM    = 8'h4D;
    localparam logic [7:0] CH_UQ    = 8'h51;
    localparam logic [7:0] CH_US    = 8'h53;
    localparam logic [7:0] CH_UT    = 8'h54;
    localparam logic [7:0] CH_UV    = 8'h56;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LE    = 8'h65;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CASE_GAP = 8'h20;

    typedef struct packed {
        logic       is_zero;
        logic       is_space;
        logic       is_digit;
        logic       is_sign;
        logic       is_dot;
        logic       is_comma;
        logic       is_exp;
        logic       is_letter;
        logic       is_cmd;
        logic [2:0] n_params;
    } cls_t;

    typedef struct packed {
        logic [3:0] phase;
        logic [2:0] group;
        logic [2:0] left;
        logic       err;
    } scan_st_t;

    typedef struct packed {
        scan_st_t st;
        logic     end_ok;
    } step_t;

    function automatic scan_st_t begin_number(scan_st_t s, cls_t c);
        scan_st_t r;
        r = s;
        if (c.is_sign)       r.phase = PH_SIGN;
        else if (c.is_digit) r.phase = PH_INT;
        else if (c.is_dot)   r.phase = PH_DOT;
        else                 r.err = 1'b1;
        return r;
    endfunction

    function automatic scan_st_t on_sep(scan_st_t s, cls_t c, logic comma_taken);
        scan_st_t r;
        r = s;
        if (c.is_space)                     r.phase = comma_taken ? PH_SEP_COMMA : PH_SEP;
        else if (c.is_comma && !comma_taken) r.phase = PH_SEP_COMMA;
        else                                r = begin_number(s, c);
        return r;
    endfunction

    function automatic step_t on_top(scan_st_t s, cls_t c);
        step_t r;
        r.st       = s;
        r.st.phase = PH_TOP;
        r.end_ok   = 1'b0;
        if (c.is_space) begin
            r.end_ok = 1'b0;
        end else if (c.is_zero) begin
            r.end_ok = 1'b1;
        end else if (c.is_letter) begin
            if (!c.is_cmd) begin
                r.st.err = 1'b1;
            end else begin
                r.st.group = c.n_params;
                r.st.left  = c.n_params;
                if (c.n_params != 3'd0) r.st.phase = PH_SEP;
            end
        end else if (s.group == 3'd0) begin
            r.st.err = 1'b1;
        end else begin
            // implicit repeat of the active command
            r.st.left = s.group;
            r.st      = on_sep(r.st, c, 1'b0);
        end
        return r;
    endfunction

    // a number ended just before c; c is judged again
    function automatic step_t number_done(scan_st_t s, cls_t c);
        step_t r;
        scan_st_t t;
        t = s;
        if (t.left != 3'd0) t.left = t.left - 3'd1;
        if (t.left != 3'd0) begin
            r.st     = on_sep(t, c, 1'b0);
            r.end_ok = 1'b0;
        end else begin
            r = on_top(t, c);
        end
        return r;
    endfunction

    function automatic step_t feed(scan_st_t s, cls_t c);
        step_t r;
        r.st     = s;
        r.end_ok = 1'b0;
        case (s.phase)
            PH_TOP:       r = on_top(s, c);
            PH_SEP:       r.st = on_sep(s, c, 1'b0);
            PH_SEP_COMMA: r.st = on_sep(s, c, 1'b1);
            PH_SIGN: begin
                if (c.is_digit)    r.st.phase = PH_INT;
                else if (c.is_dot) r.st.phase = PH_DOT;
                else               r.st.err = 1'b1;
            end
            PH_INT: begin
                if (c.is_digit)    r.st.phase = PH_INT;
                else if (c.is_dot) r.st.phase = PH_FRAC;
                else if (c.is_exp) r.st.phase = PH_EXP;
                else               r = number_done(s, c);
            end
            PH_DOT: begin
                if (c.is_digit) r.st.phase = PH_FRAC;
                else            r.st.err = 1'b1;
            end
            PH_FRAC: begin
                if (c.is_digit)    r.st.phase = PH_FRAC;
                else if (c.is_exp) r.st.phase = PH_EXP;
                else               r = number_done(s, c);
            end
            PH_EXP: begin
                if (c.is_sign)       r.st.phase = PH_EXP_SIGN;
                else if (c.is_digit) r.st.phase = PH_EXP_DIG;
                else                 r.st.err = 1'b1;
            end
            PH_EXP_SIGN: begin
                if (c.is_digit) r.st.phase = PH_EXP_DIG;
                else            r.st.err = 1'b1;
            end
            PH_EXP_DIG: begin
                if (!c.is_digit) r = number_done(s, c);
            end
            default: r.st.err = 1'b1;
        endcase
        return r;
    endfunction

endpackage

/* design/svgp_classify.sv */
// Byte classifier: character classes and command parameter counts.
module svgp_classify
    import svgp_pkg::*;
(
    input  logic [7:0] char_code,
    output cls_t       cls
);

    logic       is_upper;
    logic       is_lower;
    logic [7:0] upper;

    assign is_upper = (char_code >= CH_UA) && (char_code <= CH_UZ);
    assign is_lower = (char_code >= CH_LA) && (char_code <= CH_LZ);
    assign upper    = is_lower ? (char_code - CASE_GAP) : char_code;

    always_comb begin
        cls           = '0;
        cls.is_zero   = (char_code == CH_NUL);
        cls.is_space  = (char_code == CH_SPACE) || (char_code == CH_TAB) ||
                        (char_code == CH_CR) || (char_code == CH_LF);
        cls.is_digit  = (char_code >= CH_0) && (char_code <= CH_9);
        cls.is_sign   = (char_code == CH_PLUS) || (char_code == CH_MINUS);
        cls.is_dot    = (char_code == CH_DOT);
        cls.is_comma  = (char_code == CH_COMMA);
        cls.is_exp    = (char_code == CH_UE) || (char_code == CH_LE);
        cls.is_letter = is_upper || is_lower;
        if (cls.is_letter) begin
            case (upper)
                CH_UM, CH_UL, CH_UT: begin
                    cls.is_cmd   = 1'b1;
                    cls.n_params = 3'd2;
                end
                CH_UH, CH_UV: begin
                    cls.is_cmd   = 1'b1;
                    cls.n_params = 3'd1;
                end
                CH_UQ, CH_US: begin
                    cls.is_cmd   = 1'b1;
                    cls.n_params = 3'd4;
                end
                CH_UC: begin
                    cls.is_cmd   = 1'b1;
                    cls.n_params = 3'd6;
                end
                CH_UA: begin
                    cls.is_cmd   = 1'b1;
                    cls.n_params = 3'd7;
                end
                CH_UZ: begin
                    cls.is_cmd   = 1'b1;
                    cls.n_params = 3'd0;
                end
                default: begin
                    cls.is_cmd   = 1'b0;
                    cls.n_params = 3'd0;
                end
            endcase
        end
    end

endmodule

/* design/svgp_scan.sv */
// Grammar state register and per-byte verdict logic.
module svgp_scan
    import svgp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       adv,
    input  cls_t       cls,
    output logic [1:0] verdict,
    output logic       string_end
);

    scan_st_t st_reg;
    scan_st_t st_next;
    step_t    step;
    logic     err_after;

    assign step      = feed(st_reg, cls);
    assign err_after = st_reg.err | step.st.err;

    always_comb begin
        st_next = st_reg;
        if (adv) begin
            if (cls.is_zero) begin
                st_next = '{phase: PH_TOP, group: 3'd0, left: 3'd0, err: 1'b0};
            end else if (!st_reg.err) begin
                st_next = step.st;
            end
        end
    end

    always_comb begin
        string_end = cls.is_zero;
        if (cls.is_zero) begin
            verdict = (!err_after && step.end_ok) ? VERDICT_VALID : VERDICT_INVALID;
        end else begin
            verdict = err_after ? VERDICT_INVALID : VERDICT_OPEN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '{phase: PH_TOP, group: 3'd0, left: 3'd0, err: 1'b0};
        end else begin
            st_reg <= st_next;
        end
    end

`include "svg_path_syntax_checker_top_assert.svh"

    `SVGP_ASSERT_NOW(a_group_active, (st_reg.phase != PH_TOP), (st_reg.group != 3'd0), "mid-number phase with no active command")
    `SVGP_ASSERT_NOW(a_left_bound, 1'b1, (st_reg.left <= st_reg.group), "more parameters due than the group holds")
    `SVGP_ASSERT_NEXT(a_term_clears, (adv && cls.is_zero), ((st_reg.phase == PH_TOP) && !st_reg.err && (st_reg.group == 3'd0) && (st_reg.left == 3'd0)), "state not cleared after terminator")

endmodule

/* design/svg_path_syntax_checker_top.sv */
// SVG path data syntax checker, one byte per request.
// An input register, then a result register, lie between input accept and result valid.
// Throughput: one byte per cycle while m_ready allows; the grammar step is a single combinational pass.
// Ready flows back from the result side; an empty input stage still takes a byte.
// Reset (aresetn low, synchronous): both stages empty, grammar state between commands,
// no active command and no error recorded.
module svg_path_syntax_checker_top
    import svgp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_code,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_verdict,
    output logic       m_string_end
);

    cls_t       s_cls;
    cls_t       cls_reg;
    logic       in_valid_reg;
    logic       m_valid_reg;
    logic [1:0] verdict_reg;
    logic       string_end_reg;
    logic [1:0] verdict;
    logic       string_end;
    logic       out_free;
    logic       adv;

    svgp_classify u_classify (
        .char_code (s_char_code),
        .cls       (s_cls)
    );

    svgp_scan u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .cls        (cls_reg),
        .verdict    (verdict),
        .string_end (string_end)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign adv      = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) in_valid_reg <= s_valid;
            if (out_free) m_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) cls_reg <= s_cls;
        if (adv) begin
            verdict_reg    <= verdict;
            string_end_reg <= string_end;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_verdict    = verdict_reg;
    assign m_string_end = string_end_reg;

`include "svg_path_syntax_checker_top_assert.svh"

    `SVGP_ASSERT_NEXT(a_term_result, (adv && cls_reg.is_zero), (m_valid && m_string_end), "terminator request did not yield an end result")
    `SVGP_ASSERT_NOW(a_valid_only_at_end, (m_valid && (m_verdict == VERDICT_VALID)), m_string_end, "valid verdict before string end")

endmodule

/* bench/tb_svg_path_syntax_checker_top.sv */
// Testbench for the SVG path syntax checker: directed probes, then random path strings.
`timescale 1ns / 1ps

module tb_svg_path_syntax_checker_top;
    import svgp_pkg::*;

    typedef struct packed {
        logic [1:0] verdict;
        logic       ends;
    } outcome_t;

    // directed probe: byte, whether the outcome is fixed here, and that outcome
    typedef struct packed {
        logic [7:0] code;
        logic       fixed;
        logic [1:0] verdict;
        logic       ends;
    } probe_t;

    localparam int PROBE_COUNT = 23;
    localparam int LIVE_PER_PHASE = 425;

    localparam probe_t PROBES [PROBE_COUNT] = '{
        '{CH_NUL,   1'b1, VERDICT_VALID,   1'b1},  // empty string
        '{8'hFF,    1'b1, VERDICT_INVALID, 1'b0},
        '{CH_NUL,   1'b1, VERDICT_INVALID, 1'b1},
        '{CH_UM,    1'b0, VERDICT_OPEN,    1'b0},
        '{CH_COMMA, 1'b0, VERDICT_OPEN,    1'b0},  // comma right after the letter
        '{"1",      1'b0, VERDICT_OPEN,    1'b0},
        '{CH_MINUS, 1'b0, VERDICT_OPEN,    1'b0},  // numbers abut
        '{"2",      1'b0, VERDICT_OPEN,    1'b0},
        '{CH_DOT,   1'b0, VERDICT_OPEN,    1'b0},
        '{"5",      1'b0, VERDICT_OPEN,    1'b0},
        '{CH_LE,    1'b0, VERDICT_OPEN,    1'b0},
        '{CH_MINUS, 1'b0, VERDICT_OPEN,    1'b0},
        '{"3",      1'b0, VERDICT_OPEN,    1'b0},
        '{CH_SPACE, 1'b0, VERDICT_OPEN,    1'b0},
        '{CH_LZ,    1'b0, VERDICT_OPEN,    1'b0},
        '{CH_NUL,   1'b0, VERDICT_OPEN,    1'b0},
        '{"1",      1'b1, VERDICT_INVALID, 1'b0},  // number with no command
        '{CH_NUL,   1'b1, VERDICT_INVALID, 1'b1},
        '{CH_UZ,    1'b0, VERDICT_OPEN,    1'b0},
        '{"5",      1'b1, VERDICT_INVALID, 1'b0},  // number after close path
        '{CH_NUL,   1'b1, VERDICT_INVALID, 1'b1},
        '{CH_LE,    1'b1, VERDICT_INVALID, 1'b0},  // stray exponent letter
        '{CH_NUL,   1'b1, VERDICT_INVALID, 1'b1}
    };

    localparam logic [7:0] CMD_LETTERS [10] = '{CH_UM, CH_UL, CH_UT, CH_UH, CH_UV,
                                                CH_UQ, CH_US, CH_UC, CH_UA, CH_UZ};
    localparam logic [7:0] BLANKS [4] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_char_code;
    logic       m_valid;
    logic       m_ready;
    logic [1:0] m_verdict;
    logic       m_string_end;

    // grammar tracker state
    logic [3:0] gram_phase;
    logic [2:0] cmd_arity;
    logic [2:0] args_due;
    logic       path_bad;
    logic       path_closed;

    outcome_t   pending_outcomes [$];
    logic [7:0] path_buf [$];
    int         mismatches = 0;
    int         live_bytes = 0;
    int         idle_pct = 0;
    int         stall_pct = 0;

    svg_path_syntax_checker_top i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_char_code  (s_char_code),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_verdict    (m_verdict),
        .m_string_end (m_string_end)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic logic is_blank(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
    endfunction

    function automatic logic is_num(logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ);
    endfunction

    // parameters per group for a command letter, -1 when not a command
    function automatic int cmd_params(logic [7:0] c);
        logic [7:0] u;
        u = (c >= CH_LA && c <= CH_LZ) ? c - CASE_GAP : c;
        case (u)
            CH_UM, CH_UL, CH_UT: return 2;
            CH_UH, CH_UV:        return 1;
            CH_UQ, CH_US:        return 4;
            CH_UC:               return 6;
            CH_UA:               return 7;
            CH_UZ:               return 0;
            default:             return -1;
        endcase
    endfunction

    task automatic clear_grammar();
        gram_phase  = PH_TOP;
        cmd_arity   = 3'd0;
        args_due    = 3'd0;
        path_bad    = 1'b0;
        path_closed = 1'b0;
    endtask

    task automatic start_number(logic [7:0] c);
        if (c == CH_PLUS || c == CH_MINUS) gram_phase = PH_SIGN;
        else if (is_num(c))                gram_phase = PH_INT;
        else if (c == CH_DOT)              gram_phase = PH_DOT;
        else                               path_bad = 1'b1;
    endtask

    task automatic take_separator(logic [7:0] c, logic comma_used);
        if (is_blank(c))                       gram_phase = comma_used ? PH_SEP_COMMA : PH_SEP;
        else if (c == CH_COMMA && !comma_used) gram_phase = PH_SEP_COMMA;
        else                                   start_number(c);
    endtask

    task automatic take_outside(logic [7:0] c);
        int n;
        n = cmd_params(c);
        gram_phase = PH_TOP;
        if (is_blank(c)) begin
        end else if (c == CH_NUL) begin
            path_closed = 1'b1;
        end else if (is_alpha(c)) begin
            if (n < 0) begin
                path_bad = 1'b1;
            end else begin
                cmd_arity = 3'(n);
                args_due  = 3'(n);
                if (n > 0) gram_phase = PH_SEP;
            end
        end else if (cmd_arity == 3'd0) begin
            path_bad = 1'b1;
        end else begin
            // implicit repeat of the last command
            args_due = cmd_arity;
            take_separator(c, 1'b0);
        end
    endtask

    // number ended just before c; c is judged again
    task automatic close_number(logic [7:0] c);
        if (args_due != 3'd0) args_due = args_due - 3'd1;
        if (args_due != 3'd0) take_separator(c, 1'b0);
        else                  take_outside(c);
    endtask

    task automatic predict_byte(input logic [7:0] c, output outcome_t o);
        path_closed = 1'b0;
        if (!path_bad) begin
            case (gram_phase)
                PH_TOP:       take_outside(c);
                PH_SEP:       take_separator(c, 1'b0);
                PH_SEP_COMMA: take_separator(c, 1'b1);
                PH_SIGN: begin
                    if (is_num(c))        gram_phase = PH_INT;
                    else if (c == CH_DOT) gram_phase = PH_DOT;
                    else                  path_bad = 1'b1;
                end
                PH_INT: begin
                    if (is_num(c)) begin
                    end else if (c == CH_DOT) begin
                        gram_phase = PH_FRAC;
                    end else if (c == CH_LE || c == CH_UE) begin
                        gram_phase = PH_EXP;
                    end else begin
                        close_number(c);
                    end
                end
                PH_DOT: begin
                    if (is_num(c)) gram_phase = PH_FRAC;
                    else           path_bad = 1'b1;
                end
                PH_FRAC: begin
                    if (is_num(c)) begin
                    end else if (c == CH_LE || c == CH_UE) begin
                        gram_phase = PH_EXP;
                    end else begin
                        close_number(c);
                    end
                end
                PH_EXP: begin
                    if (c == CH_PLUS || c == CH_MINUS) gram_phase = PH_EXP_SIGN;
                    else if (is_num(c))                gram_phase = PH_EXP_DIG;
                    else                               path_bad = 1'b1;
                end
                PH_EXP_SIGN: begin
                    if (is_num(c)) gram_phase = PH_EXP_DIG;
                    else           path_bad = 1'b1;
                end
                PH_EXP_DIG: begin
                    if (!is_num(c)) close_number(c);
                end
                default: path_bad = 1'b1;
            endcase
        end
        if (c == CH_NUL) begin
            o.verdict = (!path_bad && path_closed) ? VERDICT_VALID : VERDICT_INVALID;
            o.ends    = 1'b1;
            clear_grammar();
        end else begin
            o.verdict = path_bad ? VERDICT_INVALID : VERDICT_OPEN;
            o.ends    = 1'b0;
        end
    endtask

    // one request; the outcome is fixed by the caller or predicted
    task automatic push_byte(input logic [7:0] c, input logic fixed, input outcome_t given);
        outcome_t o;
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_char_code <= c;
        do @(posedge aclk); while (!(s_valid && s_ready));
        if (!path_bad) live_bytes++;
        predict_byte(c, o);
        pending_outcomes.push_back(fixed ? given : o);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge aclk);
    endtask

    task automatic put_digits(int n);
        repeat (n) path_buf.push_back(8'(CH_0 + $urandom_range(9)));
    endtask

    task automatic put_number(logic want_sign);
        int form;
        form = $urandom_range(2);
        if (want_sign || $urandom_range(3) == 0)
            path_buf.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
        if (form != 2) put_digits($urandom_range(1, 3));
        if (form != 0) begin
            path_buf.push_back(CH_DOT);
            put_digits($urandom_range(1, 2));
        end
        if ($urandom_range(4) == 0) begin
            path_buf.push_back($urandom_range(1) ? CH_LE : CH_UE);
            if ($urandom_range(1)) path_buf.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
            put_digits($urandom_range(1, 2));
        end
    endtask

    task automatic put_gap(logic may_skip);
        int  blanks;
        logic comma;
        blanks = $urandom_range(2);
        comma  = ($urandom_range(2) == 0);
        if (!may_skip && blanks == 0 && !comma) blanks = 1;
        repeat (blanks) path_buf.push_back(BLANKS[$urandom_range(3)]);
        if (comma) begin
            path_buf.push_back(CH_COMMA);
            if ($urandom_range(1)) path_buf.push_back(BLANKS[$urandom_range(3)]);
        end
    endtask

    // mostly well-formed paths, some damaged, some plain noise
    task automatic build_path();
        int         cmds;
        int         groups;
        int         n;
        int         pick;
        int         pos;
        logic [7:0] letter;
        path_buf.delete();
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 8)) path_buf.push_back(8'($urandom_range(1, 255)));
        end else begin
            cmds = $urandom_range(1, 3);
            for (int k = 0; k < cmds; k++) begin
                pick   = (k == 0 && $urandom_range(3) != 0) ? 0 : $urandom_range(9);
                letter = CMD_LETTERS[pick] + ($urandom_range(1) ? CASE_GAP : 8'd0);
                if ($urandom_range(2) == 0) path_buf.push_back(BLANKS[$urandom_range(3)]);
                path_buf.push_back(letter);
                n      = cmd_params(letter);
                groups = (n == 0) ? 0 : $urandom_range(1, 2);
                for (int g = 0; g < groups; g++) begin
                    for (int p = 0; p < n; p++) begin
                        if (g == 0 && p == 0) begin
                            put_gap(1'b1);
                            put_number(1'b0);
                        end else if ($urandom_range(3) == 0) begin
                            put_number(1'b1);
                        end else begin
                            put_gap(1'b0);
                            put_number(1'b0);
                        end
                    end
                end
            end
            if ($urandom_range(1)) path_buf.push_back(BLANKS[$urandom_range(3)]);
            if ($urandom_range(4) == 0) begin
                pos = $urandom_range(path_buf.size() - 1);
                case ($urandom_range(3))
                    0: path_buf[pos] = 8'($urandom_range(1, 255));
                    1: path_buf.delete(pos);
                    2: path_buf.insert(pos, 8'($urandom_range(1, 255)));
                    default: while (path_buf.size() > pos) void'(path_buf.pop_back());
                endcase
            end
        end
    endtask

    // result side: random stalls, every result checked against the oldest expectation
    initial begin
        outcome_t want;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (pending_outcomes.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result verdict=%0d end=%0b",
                             $time, m_verdict, m_string_end);
                end else begin
                    want = pending_outcomes.pop_front();
                    if (m_verdict !== want.verdict) begin
                        mismatches++;
                        $display("%0t: verdict expected %0d, actual %0d",
                                 $time, want.verdict, m_verdict);
                    end
                    if (m_string_end !== want.ends) begin
                        mismatches++;
                        $display("%0t: string_end expected %0b, actual %0b",
                                 $time, want.ends, m_string_end);
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin
        outcome_t given;
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_char_code <= CH_NUL;
        clear_grammar();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < PROBE_COUNT; i++) begin
            given.verdict = PROBES[i].verdict;
            given.ends    = PROBES[i].ends;
            push_byte(PROBES[i].code, PROBES[i].fixed, given);
        end
        drain();

        live_bytes = 0;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 73; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 73; end
                default: begin idle_pct = 30; stall_pct = 30; end
            endcase
            while (live_bytes < (ph + 1) * LIVE_PER_PHASE) begin
                build_path();
                foreach (path_buf[j]) push_byte(path_buf[j], 1'b0, given);
                push_byte(CH_NUL, 1'b0, given);
            end
            // hold the sender until every outstanding request has come back
            drain();
        end
        stall_pct = 0;
        repeat (4) @(posedge aclk);
        if (mismatches == 0 && pending_outcomes.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

/* svg_path_syntax_checker_top.f */
+incdir+design
design/svgp_pkg.sv
design/svgp_classify.sv
design/svgp_scan.sv
design/svg_path_syntax_checker_top.sv
bench/tb_svg_path_syntax_checker_top.sv
